### sv/zrp_pkg.sv
// Shared types, constants and saturation helper for the Zernike radial polynomial block.
package zrp_pkg;

  typedef struct packed {
    logic [3:0]  order_n;
    logic [3:0]  order_m;
    logic [16:0] radius;
  } in_t;

  typedef struct packed {
    logic signed [31:0] poly_value;
    logic               invalid;
  } out_t;

  // Control of the shared multiply, round and subtract unit.
  typedef struct packed {
    logic load;    // capture a new product
    logic dbl;     // double the product before rounding (the 2r term)
    logic sub_en;  // subtract the old coefficient from the rounded product
  } alu_ctrl_t;

  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;
  localparam logic signed [31:0] Q30_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q30_MIN = 32'sh8000_0000;

  // Saturates a wide signed value to the Q2.30 range.
  function automatic logic signed [31:0] sat_q30(input logic signed [35:0] v);
    logic signed [31:0] res;
    if (v > 36'(Q30_MAX)) begin
      res = Q30_MAX;
    end else if (v < 36'(Q30_MIN)) begin
      res = Q30_MIN;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

### sv/zrp_alu.sv
// Shared arithmetic unit: registered r*x product, round to Q2.30, saturate, subtract.
module zrp_alu (
  input  logic                     clk_i,
  input  zrp_pkg::alu_ctrl_t       ctrl_i,
  input  logic signed [32:0]       operand_i,
  input  logic [16:0]              radius_i,
  input  logic signed [31:0]       sub_i,
  output logic signed [31:0]       value_o
);

  logic signed [50:0] prod;
  logic signed [51:0] prod_d;
  logic signed [51:0] prod_q;
  logic signed [51:0] rounded;
  logic signed [31:0] mul_val;
  logic signed [31:0] sub_val;
  logic signed [35:0] diff;

  always_comb begin
    prod = 51'(operand_i) * 51'($signed({1'b0, radius_i}));
    if (ctrl_i.dbl) begin
      prod_d = {prod, 1'b0};
    end else begin
      prod_d = {prod[50], prod};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      prod_q <= prod_d;
    end
  end

  // Adding half an LSB and dropping 16 bits gives round to nearest, ties up.
  always_comb begin
    rounded = prod_q + 52'sd32768;
    mul_val = zrp_pkg::sat_q30(rounded[51:16]);
    sub_val = ctrl_i.sub_en ? sub_i : 32'sd0;
    diff    = 36'(mul_val) - 36'(sub_val);
    value_o = zrp_pkg::sat_q30(diff);
  end

endmodule

### sv/zernike_radial_polynomial.sv
// Zernike radial polynomial R_n^m(r) by the diagonal recursion on one shared multiplier.
// One item is taken at a time; the block is ready again once the result is in the output
// register, and it accepts the next item while that result still waits for a transfer.
// With k = (n+m)/2 and D = (n-m)/2, a valid item first forms the powers r^1..r^k and then,
// for each pass d = 1..D, updates k+1-d coefficients; every coefficient goes through
// the shared multiply stage and then the round, saturate and write-back stage. Invalid
// orders (m > n, n-m odd, n above MAX_ORDER) return value 0 with the invalid flag. The
// coefficients live in a small memory of MAX_ORDER+1 entries with one write and one
// registered read per cycle.
module zernike_radial_polynomial #(
  parameter int MAX_ORDER = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  zrp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output zrp_pkg::out_t out_data_o
);

  localparam int DEPTH = MAX_ORDER + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED_MUL,
    S_SEED_WB,
    S_P_RD0,
    S_P_RD1,
    S_P_MUL,
    S_P_WB,
    S_DONE
  } state_e;

  state_e state_q;

  logic [16:0]        radius_q;
  logic [3:0]         k_q;
  logic [3:0]         j_q;
  logic [3:0]         last_q;
  logic [2:0]         dleft_q;
  logic signed [31:0] prev_q;
  logic signed [31:0] cur_q;
  logic signed [31:0] nxt_q;
  logic               bad_q;
  logic               out_valid_q;
  zrp_pkg::out_t      out_data_q;

  logic signed [31:0] mem_q [DEPTH];
  logic signed [31:0] rd_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;

  zrp_pkg::alu_ctrl_t alu_ctrl;
  logic signed [32:0] alu_operand;
  logic signed [31:0] alu_value;

  logic               accept;
  logic [4:0]         nm_sum;
  logic [3:0]         nm_diff;
  logic               in_bad;
  logic               pass_end;
  logic               out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign pass_end    = (j_q == last_q);

  always_comb begin
    nm_sum  = {1'b0, in_data_i.order_n} + {1'b0, in_data_i.order_m};
    nm_diff = in_data_i.order_n - in_data_i.order_m;
    in_bad  = (in_data_i.order_m > in_data_i.order_n)
           || (in_data_i.order_n[0] != in_data_i.order_m[0])
           || (int'(in_data_i.order_n) > MAX_ORDER);
  end

  zrp_alu u_alu (
    .clk_i     (clk_i),
    .ctrl_i    (alu_ctrl),
    .operand_i (alu_operand),
    .radius_i  (radius_q),
    .sub_i     (cur_q),
    .value_o   (alu_value)
  );

  always_comb begin
    alu_ctrl.load   = (state_q == S_SEED_MUL) || (state_q == S_P_MUL);
    alu_ctrl.dbl    = (state_q == S_P_MUL) && (j_q == 4'd0);
    alu_ctrl.sub_en = (state_q == S_P_WB);
    if (state_q == S_P_MUL) begin
      if (j_q == 4'd0) begin
        alu_operand = 33'(rd_q);
      end else begin
        alu_operand = 33'(prev_q) + 33'(rd_q);
      end
    end else begin
      alu_operand = 33'(prev_q);
    end
  end

  always_comb begin
    mem_we    = (accept && !in_bad) || (state_q == S_SEED_WB) || (state_q == S_P_WB);
    mem_waddr = (state_q == S_IDLE) ? '0 : AW'(j_q);
    mem_wdata = (state_q == S_IDLE) ? zrp_pkg::Q30_ONE : alu_value;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_q)
      S_P_RD0: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
      end
      S_P_RD1: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(1);
      end
      S_P_WB: begin
        mem_re    = !pass_end;
        mem_raddr = AW'({1'b0, j_q} + 5'd2);
      end
      default: begin
        mem_re    = 1'b0;
        mem_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radius_q    <= '0;
      k_q         <= '0;
      j_q         <= '0;
      last_q      <= '0;
      dleft_q     <= '0;
      prev_q      <= '0;
      cur_q       <= '0;
      nxt_q       <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // In S_DONE a transfer of the old result always coincides with loading the new one.
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            radius_q <= in_data_i.radius;
            k_q      <= nm_sum[4:1];
            dleft_q  <= nm_diff[3:1];
            j_q      <= 4'd1;
            bad_q    <= in_bad;
            if (in_bad) begin
              prev_q  <= '0;
              state_q <= S_DONE;
            end else begin
              prev_q <= zrp_pkg::Q30_ONE;
              // With n = m = 0 the answer is the constant term itself.
              state_q <= (nm_sum == 5'd0) ? S_DONE : S_SEED_MUL;
            end
          end
        end
        S_SEED_MUL: begin
          state_q <= S_SEED_WB;
        end
        S_SEED_WB: begin
          prev_q <= alu_value;
          if (j_q == k_q) begin
            last_q  <= k_q - 4'd1;
            state_q <= (dleft_q == 3'd0) ? S_DONE : S_P_RD0;
          end else begin
            j_q     <= j_q + 4'd1;
            state_q <= S_SEED_MUL;
          end
        end
        S_P_RD0: begin
          j_q     <= '0;
          state_q <= S_P_RD1;
        end
        S_P_RD1: begin
          cur_q   <= rd_q;
          state_q <= S_P_MUL;
        end
        S_P_MUL: begin
          nxt_q   <= rd_q;
          state_q <= S_P_WB;
        end
        S_P_WB: begin
          // The new value feeds the next coefficient; the old upper neighbor becomes current.
          prev_q <= alu_value;
          cur_q  <= nxt_q;
          if (pass_end) begin
            dleft_q <= dleft_q - 3'd1;
            last_q  <= last_q - 4'd1;
            state_q <= (dleft_q == 3'd1) ? S_DONE : S_P_RD0;
          end else begin
            j_q     <= j_q + 4'd1;
            state_q <= S_P_MUL;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q           <= 1'b1;
            out_data_q.poly_value <= prev_q;
            out_data_q.invalid    <= bad_q;
            state_q               <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
